FILE: rtl/wrth_pkg.sv
// shared constants, types and helpers of the wall residence-time histogram
`default_nettype none

package wrth_pkg;

   localparam int MAX_PARTICLES = 4096;
   localparam int NUM_BINS      = 256;
   localparam int FRAME_BITS    = 20;

   // fixed field widths
   localparam int PIDX_W     = 12;
   localparam int FRAME_IN_W = 20;
   localparam int HEIGHT_W   = 24;
   localparam int BSEL_W     = 8;
   localparam int RES_W      = 20;
   localparam int CNT_W      = 32;
   localparam int SUM_W      = 48;
   localparam int MAXRES_W   = 9;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 1;

   localparam int PADDR_BITS  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int HADDR_BITS  = $clog2(NUM_BINS);
   localparam int CLEAR_DEPTH = (MAX_PARTICLES > NUM_BINS) ? MAX_PARTICLES : NUM_BINS;
   localparam int CLR_BITS    = $clog2(CLEAR_DEPTH);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RES = 1'd1;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   localparam logic signed [HEIGHT_W-1:0] RESET_CUTOFF  = 24'sd2560;
   localparam logic [MAXRES_W-1:0]        RESET_MAX_RES = 9'd200;

   localparam logic [RES_W-1:0] RES_MAX = '1;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;
   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   localparam int PENTRY_W = 2 + 2 * FRAME_BITS;

   typedef struct packed {
      logic                  armed;
      logic                  in_visit;
      logic [FRAME_BITS-1:0] last_seen;
      logic [FRAME_BITS-1:0] entry;
   } pentry_type;

   typedef struct packed {
      logic                       req_type;
      logic [PIDX_W-1:0]          particle_index;
      logic                       is_tracked;
      logic [FRAME_IN_W-1:0]      frame_number;
      logic signed [HEIGHT_W-1:0] height;
      logic [BSEL_W-1:0]          bin_select;
   } req_beat_type;

   typedef struct packed {
      logic                en;
      logic [CLR_BITS-1:0] addr;
   } clear_type;

   typedef struct packed {
      logic                  valid;
      logic                  is_read;
      logic                  sel_ok;
      logic                  done;
      logic                  started;
      logic                  hist_inc;
      logic [FRAME_BITS-1:0] dur;
      logic [HADDR_BITS-1:0] haddr;
   } accum_cmd_type;

   typedef struct packed {
      logic             visit_done;
      logic [RES_W-1:0] residence_time;
      logic [CNT_W-1:0] completed_visits;
      logic [CNT_W-1:0] started_visits;
      logic [RES_W-1:0] longest_residence;
      logic [SUM_W-1:0] residence_sum;
      logic [CNT_W-1:0] bin_count;
   } rsp_beat_type;

   function automatic logic [CNT_W-1:0] sat_inc32(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/wrth_req_if.sv
// request channel: particle samples and bin reads
`default_nettype none

interface wrth_req_if import wrth_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic [PIDX_W-1:0]          particle_index;
   logic                       is_tracked;
   logic [FRAME_IN_W-1:0]      frame_number;
   logic signed [HEIGHT_W-1:0] height;
   logic [BSEL_W-1:0]          bin_select;

   modport source (output valid, req_type, particle_index, is_tracked, frame_number,
                   height, bin_select, input ready);
   modport sink (input valid, req_type, particle_index, is_tracked, frame_number,
                 height, bin_select, output ready);
endinterface

`default_nettype wire

FILE: rtl/wrth_rsp_if.sv
// response channel: one result beat per request
`default_nettype none

interface wrth_rsp_if import wrth_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             visit_done;
   logic [RES_W-1:0] residence_time;
   logic [CNT_W-1:0] completed_visits;
   logic [CNT_W-1:0] started_visits;
   logic [RES_W-1:0] longest_residence;
   logic [SUM_W-1:0] residence_sum;
   logic [CNT_W-1:0] bin_count;

   modport source (output valid, visit_done, residence_time, completed_visits,
                   started_visits, longest_residence, residence_sum, bin_count,
                   input ready);
   modport sink (input valid, visit_done, residence_time, completed_visits,
                 started_visits, longest_residence, residence_sum, bin_count,
                 output ready);
endinterface

`default_nettype wire

FILE: rtl/wall_residence_time_histogram_top.sv
// top level of the wall residence-time histogram
// a request accepted passes the stage 1 register, the stage 2 register and the response queue before its beat is valid
// throughput: one request per cycle while ready is high, set by the read-modify-write of the
//   particle memory and the histogram memory, each with a one-entry write forward
// up to QUEUE_DEPTH requests may be outstanding; ready drops once that many wait
// reset: synchronous; afterwards a sweep over CLEAR_DEPTH addresses (4096) zeroes both
//   memories while ready stays low; configuration writes are taken throughout
`default_nettype none

module wall_residence_time_histogram_top import wrth_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   wrth_req_if.sink                   req_bus,
   wrth_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // configuration registers
   logic signed [HEIGHT_W-1:0] cutoff_ff, cutoff_in;
   logic [MAXRES_W-1:0]        max_res_ff, max_res_in;

   // clearing sweep state
   logic                clear_ff, clear_in;
   logic [CLR_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   clear_type           clear;

   // outstanding beats: accepted and not yet delivered
   logic [QCNT_W-1:0] pend_ff, pend_in;

   logic          accept, rsp_pop;
   req_beat_type  req_beat;
   accum_cmd_type cmd;
   logic          push;
   rsp_beat_type  push_beat, out_beat;
   logic          out_valid;

   // request side
   always_comb begin
      req_bus.ready           = !clear_ff && (int'(pend_ff) < QUEUE_DEPTH);
      accept                  = req_bus.valid && req_bus.ready;
      req_beat.req_type       = req_bus.req_type;
      req_beat.particle_index = req_bus.particle_index;
      req_beat.is_tracked     = req_bus.is_tracked;
      req_beat.frame_number   = req_bus.frame_number;
      req_beat.height         = req_bus.height;
      req_beat.bin_select     = req_bus.bin_select;
   end

   // csr writes, no read-back
   always_comb begin
      cutoff_in  = cutoff_ff;
      max_res_in = max_res_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CUTOFF:  cutoff_in  = signed'(csr_data);
            CSR_MAX_RES: max_res_in = MAXRES_W'(csr_data);
         endcase
      end
   end

   // sweep counter walks every address once after reset
   always_comb begin
      clear.en   = clear_ff;
      clear.addr = clr_cnt_ff;
      clr_cnt_in = clr_cnt_ff;
      clear_in   = clear_ff;
      if (clear_ff) begin
         clr_cnt_in = clr_cnt_ff + CLR_BITS'(1);
         if (clr_cnt_ff == CLR_BITS'(CLEAR_DEPTH - 1)) clear_in = 1'b0;
      end
   end

   // stage 1: particle state lookup, update and histogram address
   wrth_track u_track (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear),
      .accept  (accept),
      .beat    (req_beat),
      .cutoff  (cutoff_ff),
      .max_res (max_res_ff),
      .cmd     (cmd)
   );

   // stage 2: histogram update or bin read, running totals
   wrth_accum u_accum (
      .clock (clock),
      .reset (reset),
      .clear (clear),
      .cmd   (cmd),
      .push  (push),
      .beat  (push_beat)
   );

   // response queue absorbs back-pressure so the pipeline never stalls
   wrth_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_beat (push_beat),
      .pop_ready (rsp_bus.ready),
      .out_valid (out_valid),
      .out_beat  (out_beat)
   );

   // response side
   always_comb begin
      rsp_bus.valid             = out_valid;
      rsp_bus.visit_done        = out_beat.visit_done;
      rsp_bus.residence_time    = out_beat.residence_time;
      rsp_bus.completed_visits  = out_beat.completed_visits;
      rsp_bus.started_visits    = out_beat.started_visits;
      rsp_bus.longest_residence = out_beat.longest_residence;
      rsp_bus.residence_sum     = out_beat.residence_sum;
      rsp_bus.bin_count         = out_beat.bin_count;
      rsp_pop                   = out_valid && rsp_bus.ready;
      pend_in                   = pend_ff + QCNT_W'(accept) - QCNT_W'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff  <= RESET_CUTOFF;
         max_res_ff <= RESET_MAX_RES;
         clear_ff   <= 1'b1;
         clr_cnt_ff <= '0;
         pend_ff    <= '0;
      end else begin
         cutoff_ff  <= cutoff_in;
         max_res_ff <= max_res_in;
         clear_ff   <= clear_in;
         clr_cnt_ff <= clr_cnt_in;
         pend_ff    <= pend_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/wrth_ram.sv
// generic single-write, single-read ram with registered read (read-first)
`default_nettype none

module wrth_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                           clock,
   input  wire logic [$clog2(DEPTH)-1:0]       rd_addr,
   output      logic [WIDTH-1:0]               rd_data,
   input  wire logic                           wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  wire logic [WIDTH-1:0]               wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/wrth_track.sv
// per-particle state memory with read-modify-write and write forwarding
`default_nettype none

module wrth_track import wrth_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire clear_type                  clear,
   input  wire logic                       accept,
   input  wire req_beat_type               beat,
   input  wire logic signed [HEIGHT_W-1:0] cutoff,
   input  wire logic [MAXRES_W-1:0]        max_res,
   output      accum_cmd_type              cmd
);

   logic                  s1_valid_ff, s1_valid_in;
   req_beat_type          s1_beat_ff;
   logic                  fwd_valid_ff, fwd_valid_in;
   logic [PADDR_BITS-1:0] fwd_addr_ff;
   pentry_type            fwd_data_ff;

   logic [PENTRY_W-1:0]   rd_data;
   logic                  wr_en;
   logic [PADDR_BITS-1:0] wr_addr;
   logic [PENTRY_W-1:0]   wr_data;

   logic [PADDR_BITS-1:0] s1_addr;
   pentry_type            cur, nxt;
   logic [FRAME_BITS-1:0] frame;
   logic                  sample_ok, above, started, done;
   logic [FRAME_BITS-1:0] dur;

   wrth_ram #(.WIDTH(PENTRY_W), .DEPTH(MAX_PARTICLES)) u_pmem (
      .clock   (clock),
      .rd_addr (PADDR_BITS'(beat.particle_index)),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_comb begin
      s1_addr   = PADDR_BITS'(s1_beat_ff.particle_index);
      cur       = (fwd_valid_ff && fwd_addr_ff == s1_addr) ? fwd_data_ff
                                                          : pentry_type'(rd_data);
      frame     = FRAME_BITS'(s1_beat_ff.frame_number);
      sample_ok = s1_valid_ff && s1_beat_ff.req_type == REQ_SAMPLE &&
                  s1_beat_ff.is_tracked && int'(s1_beat_ff.particle_index) < MAX_PARTICLES;
      above     = s1_beat_ff.height >= cutoff;
      nxt       = cur;
      started   = 1'b0;
      done      = 1'b0;
      dur       = '0;
      if (frame == '0) begin
         if (above) nxt.armed = 1'b1;
      end else if (!above) begin
         if (cur.armed) begin
            nxt.in_visit = 1'b1;
            nxt.entry    = cur.last_seen;
            started      = 1'b1;
         end
         nxt.armed = 1'b0;
      end else begin
         if (cur.in_visit) begin
            dur          = frame - cur.entry;
            nxt.in_visit = 1'b0;
            done         = 1'b1;
         end
         nxt.armed = 1'b1;
      end
      nxt.last_seen = frame;

      // zero sweep after reset owns the write port
      if (clear.en) begin
         wr_en   = int'(clear.addr) < MAX_PARTICLES;
         wr_addr = PADDR_BITS'(clear.addr);
         wr_data = '0;
      end else begin
         wr_en   = sample_ok;
         wr_addr = s1_addr;
         wr_data = nxt;
      end
      fwd_valid_in = !clear.en && sample_ok;
      s1_valid_in  = accept;

      cmd.valid    = s1_valid_ff;
      cmd.is_read  = s1_valid_ff && s1_beat_ff.req_type == REQ_READ;
      cmd.sel_ok   = int'(s1_beat_ff.bin_select) < NUM_BINS;
      cmd.done     = sample_ok && done;
      cmd.started  = sample_ok && started;
      cmd.hist_inc = sample_ok && done && (64'(dur) < 64'(max_res));
      cmd.dur      = dur;
      if (s1_beat_ff.req_type == REQ_READ) begin
         cmd.haddr = HADDR_BITS'(s1_beat_ff.bin_select);
      end else if (64'(dur) >= 64'(NUM_BINS)) begin
         cmd.haddr = HADDR_BITS'(NUM_BINS - 1);
      end else begin
         cmd.haddr = HADDR_BITS'(dur);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
      end
      s1_beat_ff  <= beat;
      fwd_addr_ff <= s1_addr;
      fwd_data_ff <= nxt;
   end

endmodule

`default_nettype wire

FILE: rtl/wrth_accum.sv
// histogram memory, running totals and result beat assembly
`default_nettype none

module wrth_accum import wrth_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire clear_type     clear,
   input  wire accum_cmd_type cmd,
   output      logic          push,
   output      rsp_beat_type  beat
);

   accum_cmd_type         s2_ff, s2_in;
   logic                  hfwd_valid_ff, hfwd_valid_in;
   logic [HADDR_BITS-1:0] hfwd_addr_ff;
   logic [CNT_W-1:0]      hfwd_data_ff;

   logic [CNT_W-1:0] completed_ff, completed_in;
   logic [CNT_W-1:0] started_ff, started_in;
   logic [RES_W-1:0] longest_ff, longest_in;
   logic [SUM_W-1:0] sum_ff, sum_in;

   logic [CNT_W-1:0]      hist_rd, hval, hnew;
   logic                  wr_en;
   logic [HADDR_BITS-1:0] wr_addr;
   logic [CNT_W-1:0]      wr_data;
   logic [RES_W-1:0]      res;
   logic [SUM_W:0]        sum_wide;

   wrth_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BINS)) u_hist (
      .clock   (clock),
      .rd_addr (cmd.haddr),
      .rd_data (hist_rd),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_comb begin
      s2_in = cmd;
      hval  = (hfwd_valid_ff && hfwd_addr_ff == s2_ff.haddr) ? hfwd_data_ff : hist_rd;
      hnew  = sat_inc32(hval);

      if (clear.en) begin
         wr_en   = int'(clear.addr) < NUM_BINS;
         wr_addr = HADDR_BITS'(clear.addr);
         wr_data = '0;
      end else begin
         wr_en   = s2_ff.valid && s2_ff.hist_inc;
         wr_addr = s2_ff.haddr;
         wr_data = hnew;
      end
      hfwd_valid_in = !clear.en && s2_ff.valid && s2_ff.hist_inc;

      res          = (64'(s2_ff.dur) > 64'(RES_MAX)) ? RES_MAX : RES_W'(s2_ff.dur);
      completed_in = completed_ff;
      started_in   = started_ff;
      longest_in   = longest_ff;
      sum_in       = sum_ff;
      sum_wide     = {1'b0, sum_ff} + (SUM_W + 1)'(s2_ff.dur);
      if (s2_ff.valid && s2_ff.started) started_in = sat_inc32(started_ff);
      if (s2_ff.valid && s2_ff.done) begin
         completed_in = sat_inc32(completed_ff);
         if (res > longest_ff) longest_in = res;
         sum_in = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
      end

      push                   = s2_ff.valid;
      beat.visit_done        = s2_ff.done;
      beat.residence_time    = s2_ff.done ? res : '0;
      beat.completed_visits  = completed_in;
      beat.started_visits    = started_in;
      beat.longest_residence = longest_in;
      beat.residence_sum     = sum_in;
      beat.bin_count         = (s2_ff.is_read && s2_ff.sel_ok) ? hval : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid   <= 1'b0;
         hfwd_valid_ff <= 1'b0;
         completed_ff  <= '0;
         started_ff    <= '0;
         longest_ff    <= '0;
         sum_ff        <= '0;
      end else begin
         s2_ff.valid   <= s2_in.valid;
         hfwd_valid_ff <= hfwd_valid_in;
         completed_ff  <= completed_in;
         started_ff    <= started_in;
         longest_ff    <= longest_in;
         sum_ff        <= sum_in;
      end
      s2_ff.is_read  <= s2_in.is_read;
      s2_ff.sel_ok   <= s2_in.sel_ok;
      s2_ff.done     <= s2_in.done;
      s2_ff.started  <= s2_in.started;
      s2_ff.hist_inc <= s2_in.hist_inc;
      s2_ff.dur      <= s2_in.dur;
      s2_ff.haddr    <= s2_in.haddr;
      hfwd_addr_ff   <= s2_ff.haddr;
      hfwd_data_ff   <= hnew;
   end

endmodule

`default_nettype wire

FILE: rtl/wrth_rsp_queue.sv
// small result queue that decouples the pipeline from response back-pressure
`default_nettype none

module wrth_rsp_queue import wrth_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire rsp_beat_type push_beat,
   input  wire logic         pop_ready,
   output      logic         out_valid,
   output      rsp_beat_type out_beat
);

   rsp_beat_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              pop;

   always_comb begin
      out_valid = count_ff != '0;
      out_beat  = entry_ff[rd_ptr_ff];
      pop       = out_valid && pop_ready;
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) entry_ff[wr_ptr_ff] <= push_beat;
   end

endmodule

`default_nettype wire
